/* sv/sdf_pkg.sv */
// sdf_pkg: shared types, widths and status codes for the segment distance field
// no dependencies
`default_nettype none
package sdf_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned GainW  = 32;
  localparam logic [31:0] GainReset = 32'd65536;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_SAT     = 2'd2,
    ST_DEGEN   = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic signed [31:0] charge_start;
    logic signed [31:0] charge_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] potential;
    logic [1:0]         status;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic signed [32:0] b_x;
    logic signed [32:0] b_y;
    logic signed [32:0] b_z;
    logic signed [32:0] v_x;
    logic signed [32:0] v_y;
    logic signed [32:0] v_z;
    logic [66:0]        a;
    logic [66:0]        n;
    logic signed [31:0] qs;
    logic signed [32:0] dq;
    logic               early;
    logic [1:0]         early_st;
  } work_t;

  // round(t*x/2^32) for an unsigned 33-bit t
  function automatic logic signed [33:0] scale_t(input logic [32:0] t,
                                                 input logic signed [32:0] x);
    logic [32:0] m;
    logic [65:0] p;
    logic [33:0] r;
    begin
      m = x[32] ? 33'(-x) : 33'(x);
      p = 66'(t) * 66'(m) + 66'h8000_0000;
      r = 34'(p >> 32);
      scale_t = x[32] ? -$signed(r) : $signed(r);
    end
  endfunction
endpackage
`default_nettype wire

/* sv/sdf_front.sv */
// sdf_front: two stage front end, differences, dot products and classification
// depends on sdf_pkg
`default_nettype none
module sdf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sdf_pkg::in_item_t in_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  output sdf_pkg::work_t       work_o,
  output logic                 valid_o,
  input  wire logic            ready_i
);
  import sdf_pkg::*;

  logic v1_q, v2_q, adv1, adv2;
  logic signed [32:0] b_q [3];
  logic signed [32:0] v_q [3];
  logic signed [31:0] qs_q;
  logic signed [32:0] dq_q;
  logic [65:0] sq_q [3];
  logic signed [67:0] bv_q [3];
  logic signed [31:0] qs2_q;
  logic signed [32:0] dq2_q;

  assign adv2 = !v2_q || ready_i;
  assign adv1 = !v1_q || adv2;
  assign ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      b_q[0] <= 33'(in_i.query_x) - 33'(in_i.start_x);
      b_q[1] <= 33'(in_i.query_y) - 33'(in_i.start_y);
      b_q[2] <= 33'(in_i.query_z) - 33'(in_i.start_z);
      v_q[0] <= 33'(in_i.end_x) - 33'(in_i.start_x);
      v_q[1] <= 33'(in_i.end_y) - 33'(in_i.start_y);
      v_q[2] <= 33'(in_i.end_z) - 33'(in_i.start_z);
      qs_q   <= in_i.charge_start;
      dq_q   <= 33'(in_i.charge_end) - 33'(in_i.charge_start);
    end
  end

  // stage 2: per axis products
  logic signed [32:0] b2 [3];
  logic signed [32:0] v2 [3];
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 66'(v_q[i] * v_q[i]);
        bv_q[i] <= 68'(b_q[i] * v_q[i]);
        b2[i]   <= b_q[i];
        v2[i]   <= v_q[i];
      end
      qs2_q <= qs_q;
      dq2_q <= dq_q;
    end
  end

  // sums and classification feed the queue directly
  logic [66:0] a_s;
  logic signed [68:0] n_s;
  always_comb begin
    a_s = 67'(sq_q[0]) + 67'(sq_q[1]) + 67'(sq_q[2]);
    n_s = 69'(bv_q[0]) + 69'(bv_q[1]) + 69'(bv_q[2]);
    work_o.qs = qs2_q;
    work_o.dq = dq2_q;
    work_o.b_x = b2[0];
    work_o.b_y = b2[1];
    work_o.b_z = b2[2];
    work_o.v_x = v2[0];
    work_o.v_y = v2[1];
    work_o.v_z = v2[2];
    work_o.a = a_s;
    work_o.n = n_s[66:0];
    work_o.early = 1'b0;
    work_o.early_st = ST_INSIDE;
    if (a_s == '0) begin
      work_o.early = 1'b1;
      work_o.early_st = ST_DEGEN;
    end else if (n_s < 0 || n_s > $signed({2'b00, a_s})) begin
      work_o.early = 1'b1;
      work_o.early_st = ST_OUTSIDE;
    end
  end
  assign valid_o = v2_q;
endmodule
`default_nettype wire

/* sv/sdf_queue.sv */
// sdf_queue: small fifo of classified work between front and back
// depends on sdf_pkg
`default_nettype none
module sdf_queue #(
  parameter int unsigned Depth = sdf_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sdf_pkg::work_t wr_data_i,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  output sdf_pkg::work_t     rd_data_o,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i
);
  import sdf_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q < (AW+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/sdf_div.sv */
// sdf_div: pipelined restoring divider, a few quotient bits per stage
// no package use beyond widths given as parameters
`default_nettype none
module sdf_div #(
  parameter int unsigned NumW = 100,
  parameter int unsigned DenW = 67,
  parameter int unsigned QW = 34,
  parameter int unsigned BitsPerStage = 2,
  parameter int unsigned SideW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quo_o,
  output logic                 ovf_o,
  output logic [SideW-1:0]     side_o
);
  // quotient of bits at or above QW flagged as overflow, low QW bits computed
  localparam int unsigned Stages = (QW + BitsPerStage - 1) / BitsPerStage;
  localparam int unsigned QP = Stages * BitsPerStage;
  localparam int unsigned RW = DenW + 1;

  logic v_q [Stages+1];
  logic [RW-1:0] r_q [Stages+1];
  logic [NumW-1:0] n_q [Stages+1];
  logic [DenW-1:0] d_q [Stages+1];
  logic [QP-1:0] qt_q [Stages+1];
  logic ovf_q [Stages+1];
  logic [SideW-1:0] s_q [Stages+1];

  always_comb begin
    v_q[0] = valid_i;
    n_q[0] = num_i;
    d_q[0] = den_i;
    // top part: num >> QP must be below den
    ovf_q[0] = (num_i >> QP) >= NumW'(den_i);
    r_q[0] = RW'(num_i >> QP);
    qt_q[0] = '0;
    s_q[0] = side_i;
  end

  for (genvar g = 0; g < Stages; g++) begin : g_st
    logic [RW-1:0] r;
    logic [QP-1:0] qt;
    always_comb begin
      r = r_q[g];
      qt = qt_q[g];
      for (int k = 0; k < BitsPerStage; k++) begin
        r = {r[RW-2:0], n_q[g][QP - 1 - g*BitsPerStage - k]};
        qt = {qt[QP-2:0], 1'b0};
        if (r >= RW'(d_q[g])) begin
          r = r - RW'(d_q[g]);
          qt[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[g+1] <= 1'b0;
      else if (en_i) v_q[g+1] <= v_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g+1] <= r;
        qt_q[g+1] <= qt;
        n_q[g+1] <= n_q[g];
        d_q[g+1] <= d_q[g];
        ovf_q[g+1] <= ovf_q[g] || (QP > QW && (qt >> QW) != '0 && g == Stages-1);
        s_q[g+1] <= s_q[g];
      end
    end
  end

  assign valid_o = v_q[Stages];
  assign quo_o = qt_q[Stages][QW-1:0];
  assign ovf_o = ovf_q[Stages] || ((qt_q[Stages] >> QW) != '0);
  assign side_o = s_q[Stages];
endmodule
`default_nettype wire

/* sv/sdf_back.sv */
// sdf_back: ratio, residual distance, charge and final quotient with saturation
// depends on sdf_pkg and sdf_div
`default_nettype none
module sdf_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      gain_i,
  input  wire sdf_pkg::work_t   work_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  output sdf_pkg::out_item_t    out_o,
  output logic                  valid_o,
  input  wire logic             ready_i
);
  import sdf_pkg::*;

  // whole back end advances together; the output register with skid decouples
  logic en, skid_v_q, out_v_q;
  out_item_t out_q, skid_q;
  assign en = !skid_v_q;
  assign ready_o = en;

  // ratio divider: t = floor(n*2^32/a), side carries nothing
  logic tv;
  logic [32:0] t_raw;
  logic t_ovf;
  logic [0:0] t_side;
  sdf_div #(.NumW(99), .DenW(67), .QW(33), .BitsPerStage(3), .SideW(1)) u_tdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i),
    .num_i({work_i.n, 32'd0}), .den_i(work_i.a), .side_i(1'b0),
    .valid_o(tv), .quo_o(t_raw), .ovf_o(t_ovf), .side_o(t_side)
  );

  // matching delay line for the classified item
  localparam int unsigned TDly = (33 + 2) / 3;
  work_t wd_q [TDly+1];
  assign wd_q[0] = work_i;
  for (genvar g = 0; g < TDly; g++) begin : g_wd
    always_ff @(posedge clk_i) if (en) wd_q[g+1] <= wd_q[g];
  end
  work_t wt;
  assign wt = wd_q[TDly];
  logic [32:0] t;
  assign t = (t_ovf || t_side[0]) ? 33'h1_0000_0000 : t_raw;

  // stage r: residuals and charge
  logic rv_q;
  logic signed [33:0] r_q [3];
  logic signed [33:0] q_q;
  logic early_q;
  logic [1:0] est_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (en) rv_q <= tv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0] <= 34'(wt.b_x) - scale_t(t, wt.v_x);
      r_q[1] <= 34'(wt.b_y) - scale_t(t, wt.v_y);
      r_q[2] <= 34'(wt.b_z) - scale_t(t, wt.v_z);
      q_q <= 34'(wt.qs) + scale_t(t, wt.dq);
      early_q <= wt.early;
      est_q <= wt.early_st;
    end
  end

  // stage s: squares and gain*|q|
  logic sv_q;
  logic [67:0] sq_q [3];
  logic [65:0] gq_q;
  logic neg_q, early2_q;
  logic [1:0] est2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= 1'b0;
    else if (en) sv_q <= rv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= 68'(r_q[i] * r_q[i]);
      gq_q <= 66'(gain_i) * 66'(q_q[33] ? 34'(-q_q) : 34'(q_q));
      neg_q <= q_q[33];
      early2_q <= early_q;
      est2_q <= est_q;
    end
  end

  logic [69:0] d2;
  assign d2 = 70'(sq_q[0]) + 70'(sq_q[1]) + 70'(sq_q[2]);

  // final quotient
  logic fv, f_ovf;
  logic [32:0] f_quo;
  logic [3:0] f_side;
  logic d2z;
  assign d2z = d2 == '0;
  sdf_div #(.NumW(82), .DenW(70), .QW(33), .BitsPerStage(3), .SideW(4)) u_pdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv_q),
    .num_i({gq_q, 16'd0}), .den_i(d2z ? 70'd1 : d2),
    .side_i({neg_q, early2_q, d2z, 1'b0}),
    .valid_o(fv), .quo_o(f_quo), .ovf_o(f_ovf), .side_o(f_side)
  );

  // early status aligned with the final divider
  logic [1:0] est_d_q [TDly+1];
  assign est_d_q[0] = est2_q;
  for (genvar g = 0; g < TDly; g++) begin : g_est
    always_ff @(posedge clk_i) if (en) est_d_q[g+1] <= est_d_q[g];
  end

  out_item_t res;
  always_comb begin
    res.potential = '0;
    res.status = ST_INSIDE;
    if (f_side[2]) begin
      res.status = est_d_q[TDly];
    end else if (f_side[1]) begin
      res.potential = 32'sh7FFF_FFFF;
      res.status = ST_SAT;
    end else if (f_ovf || f_quo > (f_side[3] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF)) begin
      res.potential = f_side[3] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res.status = ST_SAT;
    end else begin
      res.potential = f_side[3] ? 32'(-f_quo) : f_quo[31:0];
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || ready_i) begin
        out_v_q <= skid_v_q || (en && fv);
        skid_v_q <= 1'b0;
      end else if (en && fv) begin
        skid_v_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (!out_v_q || ready_i) out_q <= skid_v_q ? skid_q : res;
    if (en && fv) skid_q <= res;
  end
  assign out_o = out_q;
  assign valid_o = out_v_q;
endmodule
`default_nettype wire

/* sv/segment_distance_field.sv */
// segment_distance_field: field of a charged 3d segment at a query point
// top level; depends on sdf_pkg, sdf_front, sdf_queue, sdf_back
//
// usage:
//  - input channel in_valid_i/in_ready_o carries in_data_i (in_item_t);
//    a transaction happens when both are high at a rising edge
//  - result channel out_valid_o/out_ready_i carries out_data_o (out_item_t),
//    one result per input transaction, in order
//  - gain_we_i/gain_i writes the field constant k (reset 1.0); the user writes it
//    only when idle, which the block does not enforce
// throughput: one transaction per cycle while the receiver takes results
// out_valid_o rises after two front stages, queue write, two 11-stage pipelined
//   dividers (projection ratio, final quotient), two product stages, output register
// the front part stalls only when the work queue is full; the back pipeline
// halts as a whole once its skid entry holds a result the receiver has not taken
// reset clears all valid flags and queue pointers, restores the gain, clears no data
`default_nettype none
module segment_distance_field #(
  parameter int unsigned QueueDepth = sdf_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sdf_pkg::in_item_t  in_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output sdf_pkg::out_item_t      out_data_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire logic               gain_we_i,
  input  wire logic [31:0]        gain_i
);
  import sdf_pkg::*;

  logic [31:0] gain_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gain_q <= GainReset;
    else if (gain_we_i) gain_q <= gain_i;
  end

  work_t fw, qw;
  logic fv, fr, qv, qr;

  sdf_front u_front (
    .clk_i, .rst_ni, .in_i(in_data_i), .valid_i(in_valid_i), .ready_o(in_ready_o),
    .work_o(fw), .valid_o(fv), .ready_i(fr)
  );
  sdf_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_data_i(fw), .wr_valid_i(fv), .wr_ready_o(fr),
    .rd_data_o(qw), .rd_valid_o(qv), .rd_ready_i(qr)
  );
  sdf_back u_back (
    .clk_i, .rst_ni, .gain_i(gain_q), .work_i(qw), .valid_i(qv), .ready_o(qr),
    .out_o(out_data_o), .valid_o(out_valid_o), .ready_i(out_ready_i)
  );
endmodule
`default_nettype wire

/* sv/sdf_checker.sv */
// sdf_checker: port level checks for segment_distance_field, bound to the top
// depends on sdf_pkg
`default_nettype none
module sdf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire sdf_pkg::out_item_t out_data_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i
);
  import sdf_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_OUTSIDE || out_data_o.status == ST_DEGEN)
      |-> out_data_o.potential == '0)
    else $error("nonzero potential with zero status");
  a_sat_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_SAT |->
      (out_data_o.potential == 32'sh7FFF_FFFF || out_data_o.potential == 32'sh8000_0000))
    else $error("saturated status without extreme value");
endmodule
bind segment_distance_field sdf_checker u_sdf_checker (
  .clk_i, .rst_ni, .out_data_o, .out_valid_o, .out_ready_i
);
`default_nettype wire
